/* rtl/dith_pkg.sv */
// Shared types, constants and arithmetic helpers for the RGB888 to RGB555
// error-diffusion dither. No dependencies.

package dith_pkg;

    // Configuration register indexes and field widths
    localparam int                 CFG_INDEX_W      = 2;
    localparam int                 CFG_DATA_W       = 13;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    localparam int IMG_WIDTH_W  = 11;
    localparam int IMG_HEIGHT_W = 13;
    localparam logic [IMG_WIDTH_W-1:0]  IMG_WIDTH_RESET  = 11'd640;
    localparam logic [IMG_HEIGHT_W-1:0] IMG_HEIGHT_RESET = 13'd480;

    localparam int MAX_WIDTH_DEFAULT = 1024;
    localparam int HEIGHT_LIMIT      = 4096;
    localparam int ROW_W             = 12;

    // Pixel and error-term widths
    localparam int CHAN_W   = 8;
    localparam int OUT_W    = 5;
    localparam int TERM_W   = 3;   // 7/16 and 5/16 terms
    localparam int DL_W     = 2;   // 3/16 term
    localparam int ENTRY_W  = TERM_W + DL_W;
    localparam int NUM_CHAN = 3;
    localparam int LINE_W   = NUM_CHAN * ENTRY_W;
    localparam int DELTA_W  = NUM_CHAN * TERM_W;

    // Rounding and diffusion constants
    localparam logic [CHAN_W-1:0] ROUND_ADD  = 8'h04;
    localparam logic [CHAN_W-1:0] QUANT_MASK = 8'hF8;
    localparam logic [CHAN_W-1:0] CHAN_MAX   = 8'd255;
    localparam logic [7:0]        W_RIGHT     = 8'd7;
    localparam logic [7:0]        W_DOWN      = 8'd5;
    localparam logic [7:0]        W_DOWN_LEFT = 8'd3;
    localparam logic [7:0]        SPREAD_BIAS = 8'd8;

    // Status of the pixel held in the compute stage
    typedef struct packed {
        logic last_col;
        logic last_row;
        logic row_nz;
    } pos_t;

    // Adds a small signed correction to a channel value and clamps to 0..255.
    function automatic logic [CHAN_W-1:0] clamp_add(input logic [CHAN_W-1:0] v,
                                                    input logic [TERM_W-1:0] d);
        logic [9:0] s;
        s = {2'b00, v} + {{(10-TERM_W){d[TERM_W-1]}}, d};
        if (s[9])
            clamp_add = '0;
        else if (s[8])
            clamp_add = CHAN_MAX;
        else
            clamp_add = s[7:0];
    endfunction

    // w*e + 8 in eight bits; bits 7..4 then hold floor((w*e+8)/16).
    function automatic logic [7:0] spread_sum(input logic [3:0] e, input logic [7:0] w);
        logic [7:0] ext;
        ext = {{4{e[3]}}, e};
        spread_sum = 8'(ext * w) + SPREAD_BIAS;
    endfunction

endpackage

/* rtl/dith_line_mem.sv */
// Line store of the dither: one entry of error terms per column.
// Synchronous write, registered read. No dependencies.

module dith_line_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 15
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/dith_chan.sv */
// Per-channel dither arithmetic: applies incoming error terms, rounds to five
// bits and forms the outgoing error terms. Depends on dith_pkg.

module dith_chan
    import dith_pkg::*;
(
    input  logic [CHAN_W-1:0]  pix,
    input  logic [ENTRY_W-1:0] line_entry,
    input  logic [TERM_W-1:0]  right_term,
    output logic [OUT_W-1:0]   quant,
    output logic [TERM_W-1:0]  t_right,
    output logic [TERM_W-1:0]  t_down,
    output logic [DL_W-1:0]    t_down_left
);

    logic [CHAN_W-1:0] v_above;
    logic [CHAN_W-1:0] v_diag;
    logic [CHAN_W-1:0] v_full;
    logic [CHAN_W:0]   v_round;
    logic [CHAN_W-1:0] q_sat;
    logic [CHAN_W-1:0] q;
    logic [9:0]        err_wide;
    logic [3:0]        err;
    logic [7:0]        p_right;
    logic [7:0]        p_down;
    logic [7:0]        p_dl;

    always_comb
    begin
        // Terms arrive in a fixed order, each partial sum clamped.
        v_above = clamp_add(pix, line_entry[TERM_W-1:0]);
        v_diag  = clamp_add(v_above, {line_entry[ENTRY_W-1], line_entry[ENTRY_W-1:TERM_W]});
        v_full  = clamp_add(v_diag, right_term);

        v_round = {1'b0, v_full} + {1'b0, ROUND_ADD};
        q_sat   = v_round[CHAN_W] ? CHAN_MAX : v_round[CHAN_W-1:0];
        q       = ((|(v_full & ROUND_ADD)) ? q_sat : v_full) & QUANT_MASK;

        // The error always lies in -4..7.
        err_wide = {2'b00, v_full} - {2'b00, q};
        err      = err_wide[3:0];

        p_right = spread_sum(err, W_RIGHT);
        p_down  = spread_sum(err, W_DOWN);
        p_dl    = spread_sum(err, W_DOWN_LEFT);
    end

    assign quant       = q[CHAN_W-1:CHAN_W-OUT_W];
    assign t_right     = p_right[4+TERM_W-1:4];
    assign t_down      = p_down[4+TERM_W-1:4];
    assign t_down_left = p_dl[4+DL_W-1:4];

endmodule

/* rtl/dither_rgb24_to_rgb15_top.sv */
// Top level of the RGB888 to RGB555 error-diffusion dither.
// Depends on dith_pkg, dith_line_mem and dith_chan.

// The block takes one pixel per clock in raster order and returns one
// dithered pixel per clock from its output register. At the input
// transaction the line store is read at the pixel's column; in the next
// stage the three channels are rounded and their error terms written back to
// the line store through its single write port. The last pixel of a row needs
// two writes, so its second write is held and issued once the write port is
// free, at the latest while the first pixel of the next row, which writes
// nothing, passes; reads of an entry that is being or about to be written
// are forwarded. The output register lets a new pixel enter while a finished
// one waits, so throughput is one pixel per clock whenever the output side
// takes one per clock. Width and height take effect at once when written;
// zero counts as one and larger values saturate at MAX_WIDTH and 4096.

module dither_rgb24_to_rgb15_top
    import dith_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [CHAN_W-1:0]      red_in,
    input  logic [CHAN_W-1:0]      green_in,
    input  logic [CHAN_W-1:0]      blue_in,
    input  logic [CHAN_W-1:0]      alpha_in,

    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [OUT_W-1:0]       red_out,
    output logic [OUT_W-1:0]       green_out,
    output logic [OUT_W-1:0]       blue_out,
    output logic [CHAN_W-1:0]      alpha_out,
    output logic                   frame_end
);

    localparam int AW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CMPW = (AW > IMG_WIDTH_W) ? AW : IMG_WIDTH_W;

    // Configuration
    logic [IMG_WIDTH_W-1:0]  width_reg;
    logic [IMG_HEIGHT_W-1:0] height_reg;

    // Position in the image
    logic [AW-1:0]    col_count_reg, col_count_next;
    logic [ROW_W-1:0] row_count_reg, row_count_next;

    logic [IMG_WIDTH_W-1:0]  wlast_raw;
    logic [CMPW-1:0]         wlast_ext;
    logic [AW-1:0]           w_last;
    logic [IMG_HEIGHT_W-1:0] hlast_raw;
    logic [ROW_W-1:0]        h_last;
    logic                    last_col0;
    logic                    last_row0;
    logic [AW-1:0]           col0;
    logic [ROW_W-1:0]        row0;
    logic                    accept;

    // Compute stage
    logic                s1_valid_reg, s1_valid_next;
    pos_t                s1_pos_reg;
    logic [AW-1:0]       s1_col_reg;
    logic [CHAN_W-1:0]   s1_red_reg, s1_green_reg, s1_blue_reg, s1_alpha_reg;
    logic                fwd_hit_reg;
    logic [LINE_W-1:0]   fwd_data_reg;
    logic                s1_fire;

    logic [LINE_W-1:0]   line_q;
    logic [LINE_W-1:0]   line_eff;
    logic [DELTA_W-1:0]  right_reg, right_next;
    logic [DELTA_W-1:0]  held_reg;
    logic [DELTA_W-1:0]  new_right;
    logic [DELTA_W-1:0]  new_held;
    logic [LINE_W-1:0]   entry_prev;
    logic [LINE_W-1:0]   entry_last;
    logic [OUT_W-1:0]    quant [NUM_CHAN];
    logic [DL_W-1:0]     t_dl [NUM_CHAN];
    logic [CHAN_W-1:0]   pix [NUM_CHAN];

    // Line store write port and the deferred end-of-row write
    logic                wr_prev;
    logic                wr_last;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [LINE_W-1:0]   mem_wdata;
    logic                pend_valid_reg, pend_valid_next;
    logic [AW-1:0]       pend_addr_reg, pend_addr_next;
    logic [LINE_W-1:0]   pend_data_reg, pend_data_next;
    logic                pend_issue;
    logic                fwd_hit_next;
    logic [LINE_W-1:0]   fwd_data_next;

    // Output register
    logic                out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]    red_out_reg, green_out_reg, blue_out_reg;
    logic [CHAN_W-1:0]   alpha_out_reg;
    logic                frame_end_reg;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= IMG_WIDTH_RESET;
            height_reg <= IMG_HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data[IMG_WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg_data[IMG_HEIGHT_W-1:0];
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Position of the incoming pixel
    // ------------------------------------------------------------------
    always_comb
    begin
        wlast_raw = (width_reg == '0) ? '0 : width_reg - 1'b1;
        wlast_ext = CMPW'(wlast_raw);
        w_last    = (wlast_ext > CMPW'(MAX_WIDTH - 1)) ? AW'(MAX_WIDTH - 1) : AW'(wlast_ext);

        hlast_raw = (height_reg == '0) ? '0 : height_reg - 1'b1;
        h_last    = (hlast_raw > IMG_HEIGHT_W'(HEIGHT_LIMIT - 1)) ?
                    ROW_W'(HEIGHT_LIMIT - 1) : hlast_raw[ROW_W-1:0];

        // A count at or past the bound is treated as the last column or row.
        last_col0 = (col_count_reg >= w_last);
        last_row0 = (row_count_reg >= h_last);
        col0      = last_col0 ? w_last : col_count_reg;
        row0      = last_row0 ? h_last : row_count_reg;
    end

    assign s1_fire  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_fire;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (accept)
        begin
            if (last_col0)
            begin
                col_count_next = '0;
                row_count_next = last_row0 ? '0 : row0 + 1'b1;
            end
            else
            begin
                col_count_next = col0 + 1'b1;
                row_count_next = row0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Line store
    // ------------------------------------------------------------------
    dith_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW),
        .DW    (LINE_W)
    ) u_line_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (accept),
        .raddr (col0),
        .rdata (line_q)
    );

    always_comb
    begin
        wr_prev = s1_fire && !s1_pos_reg.last_row && (s1_col_reg != '0);
        wr_last = s1_fire && !s1_pos_reg.last_row && s1_pos_reg.last_col;

        pend_issue = pend_valid_reg && !wr_prev && !wr_last;

        mem_we    = wr_prev || wr_last || pend_valid_reg;
        mem_waddr = pend_addr_reg;
        mem_wdata = pend_data_reg;
        if (wr_prev)
        begin
            mem_waddr = s1_col_reg - 1'b1;
            mem_wdata = entry_prev;
        end
        else if (wr_last)
        begin
            mem_waddr = s1_col_reg;
            mem_wdata = entry_last;
        end

        pend_valid_next = pend_valid_reg && !pend_issue;
        pend_addr_next  = pend_addr_reg;
        pend_data_next  = pend_data_reg;
        if (wr_prev && wr_last)
        begin
            pend_valid_next = 1'b1;
            pend_addr_next  = s1_col_reg;
            pend_data_next  = entry_last;
        end

        // The store returns the old value on a same-cycle write, and a held
        // write may not have reached it yet: both are bypassed.
        fwd_hit_next  = 1'b0;
        fwd_data_next = mem_wdata;
        if (mem_we && (mem_waddr == col0))
        begin
            fwd_hit_next = 1'b1;
        end
        else if (pend_valid_reg && !pend_issue && (pend_addr_reg == col0))
        begin
            fwd_hit_next  = 1'b1;
            fwd_data_next = pend_data_reg;
        end
    end

    // ------------------------------------------------------------------
    // Compute stage
    // ------------------------------------------------------------------
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg          <= col0;
            s1_pos_reg.last_col <= last_col0;
            s1_pos_reg.last_row <= last_row0;
            s1_pos_reg.row_nz   <= (row0 != '0);
            s1_red_reg          <= red_in;
            s1_green_reg        <= green_in;
            s1_blue_reg         <= blue_in;
            s1_alpha_reg        <= alpha_in;
            fwd_hit_reg         <= fwd_hit_next;
            fwd_data_reg        <= fwd_data_next;
        end
        if (wr_prev && wr_last)
        begin
            pend_addr_reg <= pend_addr_next;
            pend_data_reg <= pend_data_next;
        end
    end

    assign line_eff = !s1_pos_reg.row_nz ? '0 : (fwd_hit_reg ? fwd_data_reg : line_q);
    assign pix[0]   = s1_red_reg;
    assign pix[1]   = s1_green_reg;
    assign pix[2]   = s1_blue_reg;

    for (genvar ch = 0; ch < NUM_CHAN; ch++)
    begin : g_chan
        dith_chan u_chan (
            .pix         (pix[ch]),
            .line_entry  (line_eff[ch*ENTRY_W +: ENTRY_W]),
            .right_term  (right_reg[ch*TERM_W +: TERM_W]),
            .quant       (quant[ch]),
            .t_right     (new_right[ch*TERM_W +: TERM_W]),
            .t_down      (new_held[ch*TERM_W +: TERM_W]),
            .t_down_left (t_dl[ch])
        );

        assign entry_prev[ch*ENTRY_W +: ENTRY_W] = {t_dl[ch], held_reg[ch*TERM_W +: TERM_W]};
        assign entry_last[ch*ENTRY_W +: ENTRY_W] = {{DL_W{1'b0}}, new_held[ch*TERM_W +: TERM_W]};
    end

    assign right_next = s1_pos_reg.last_col ? '0 : new_right;

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            red_out_reg   <= quant[0];
            green_out_reg <= quant[1];
            blue_out_reg  <= quant[2];
            alpha_out_reg <= s1_alpha_reg;
            frame_end_reg <= s1_pos_reg.last_col && s1_pos_reg.last_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg  <= '0;
            row_count_reg  <= '0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            right_reg      <= '0;
            held_reg       <= '0;
        end
        else
        begin
            col_count_reg  <= col_count_next;
            row_count_reg  <= row_count_next;
            s1_valid_reg   <= s1_valid_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
            if (s1_fire)
            begin
                right_reg <= right_next;
                held_reg  <= new_held;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign red_out   = red_out_reg;
    assign green_out = green_out_reg;
    assign blue_out  = blue_out_reg;
    assign alpha_out = alpha_out_reg;
    assign frame_end = frame_end_reg;

`ifndef SYNTH
    // An accepted transaction always lands in the compute stage.
    a_accept_captured: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> s1_valid_reg)
        else $error("accepted pixel not captured in compute stage");

    // The second end-of-row write is held for the following cycle.
    a_tail_deferred: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_prev && wr_last) |=> (pend_valid_reg && pend_addr_reg == $past(s1_col_reg)))
        else $error("end-of-row line store write was not deferred");

    // The column counter never leaves the line store.
    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_count_reg <= AW'(MAX_WIDTH - 1))
        else $error("column counter beyond line store depth");
`endif

endmodule

/* tb/sv/dither_rgb24_to_rgb15_top_tb.sv */
// Self-checking testbench for the RGB888 to RGB555 error-diffusion dither.
// Depends on dith_pkg and dither_rgb24_to_rgb15_top; a scoreboard class keeps
// its own diffusion state and checks each output transaction in order.

module dither_rgb24_to_rgb15_top_tb
    import dith_pkg::*;
();

    localparam int MAX_W = MAX_WIDTH_DEFAULT;
    localparam int HALF_PERIOD = 6;
    localparam int RANDOM_PIXELS = 600;
    localparam int CALM_PIXELS = 520;

    // Indexes that decode to no register; writes to them must change nothing.
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

    typedef enum int {TEXTURE_NOISE, TEXTURE_FLAT, TEXTURE_EXTREME} texture_e;

    typedef struct packed {
        logic [OUT_W-1:0]  red;
        logic [OUT_W-1:0]  green;
        logic [OUT_W-1:0]  blue;
        logic [CHAN_W-1:0] alpha;
        logic              frame_end;
    } rgb15_px_t;

    class dither_scoreboard;
        logic [IMG_WIDTH_W-1:0]  width_cfg;
        logic [IMG_HEIGHT_W-1:0] height_cfg;
        logic [LINE_W-1:0]       line_store [MAX_W];
        logic [DELTA_W-1:0]      held_delta;
        logic [DELTA_W-1:0]      right_delta;
        int                      col_count;
        int                      row_count;
        rgb15_px_t               expected_pixels [$];
        int                      failures;

        function new();
            width_cfg = IMG_WIDTH_RESET;
            height_cfg = IMG_HEIGHT_RESET;
            foreach (line_store[i])
                line_store[i] = '0;
            held_delta = '0;
            right_delta = '0;
            col_count = 0;
            row_count = 0;
            failures = 0;
        endfunction

        function void write_reg(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
            if (idx == REG_IMAGE_WIDTH)
                width_cfg = data[IMG_WIDTH_W-1:0];
            else if (idx == REG_IMAGE_HEIGHT)
                height_cfg = data[IMG_HEIGHT_W-1:0];
        endfunction

        function int active_width();
            if (width_cfg == 0)
                return 1;
            return (width_cfg > MAX_W) ? MAX_W : int'(width_cfg);
        endfunction

        function int active_height();
            if (height_cfg == 0)
                return 1;
            return (height_cfg > HEIGHT_LIMIT) ? HEIGHT_LIMIT : int'(height_cfg);
        endfunction

        function int sat_byte(input int x);
            if (x < 0)
                return 0;
            return (x > 255) ? 255 : x;
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        function bit at_row_start();
            return col_count == 0;
        endfunction

        function bit at_frame_start();
            return col_count == 0 && row_count == 0;
        endfunction

        // Rounds one accepted pixel and spreads its error to the neighbors.
        function void note_pixel(input logic [CHAN_W-1:0] r, g, b, a);
            int w, h, col, row, v, q, e, t7, t5, t3;
            bit last_col, last_row;
            logic [LINE_W-1:0] above, prev_entry, last_entry;
            logic [DELTA_W-1:0] next_right, next_held;
            logic [CHAN_W-1:0] chan [NUM_CHAN];
            logic [OUT_W-1:0] rounded [NUM_CHAN];
            rgb15_px_t px;

            chan[0] = r;
            chan[1] = g;
            chan[2] = b;
            w = active_width();
            h = active_height();
            col = (col_count < w) ? col_count : w - 1;
            row = (row_count < h) ? row_count : h - 1;
            last_col = (col == w - 1);
            last_row = (row == h - 1);
            above = (row > 0) ? line_store[col] : '0;
            next_right = '0;
            next_held = '0;
            prev_entry = '0;
            last_entry = '0;

            for (int ch = 0; ch < NUM_CHAN; ch++)
            begin
                // Terms arrive one at a time: down, down-left, then right.
                v = chan[ch];
                v = sat_byte(v + int'($signed(above[ENTRY_W*ch +: TERM_W])));
                v = sat_byte(v + int'($signed(above[ENTRY_W*ch+TERM_W +: DL_W])));
                v = sat_byte(v + int'($signed(right_delta[TERM_W*ch +: TERM_W])));
                q = v;
                if ((q & 4) != 0)
                    q = (q + 4 > 255) ? 255 : q + 4;
                q = q & 'hF8;
                e = v - q;
                rounded[ch] = OUT_W'(q >> 3);
                t7 = (7 * e + 8) >>> 4;
                t5 = (5 * e + 8) >>> 4;
                t3 = (3 * e + 8) >>> 4;
                next_right[TERM_W*ch +: TERM_W] = TERM_W'(t7);
                next_held[TERM_W*ch +: TERM_W] = TERM_W'(t5);
                prev_entry[ENTRY_W*ch +: ENTRY_W] =
                    {DL_W'(t3), held_delta[TERM_W*ch +: TERM_W]};
                last_entry[ENTRY_W*ch +: ENTRY_W] = {{DL_W{1'b0}}, TERM_W'(t5)};
            end

            px.red = rounded[0];
            px.green = rounded[1];
            px.blue = rounded[2];
            px.alpha = a;
            px.frame_end = last_col && last_row;
            expected_pixels.push_back(px);

            // The entry left of this pixel is completed now; the last column
            // also fills its own entry since nothing follows it on the row.
            if (!last_row)
            begin
                if (col > 0)
                    line_store[col-1] = prev_entry;
                if (last_col)
                    line_store[col] = last_entry;
            end
            held_delta = next_held;
            if (last_col)
            begin
                right_delta = '0;
                col_count = 0;
                row_count = last_row ? 0 : row + 1;
            end
            else
            begin
                right_delta = next_right;
                col_count = col + 1;
                row_count = row;
            end
        endfunction

        function void compare_field(input string name, input int want, input int got);
            if (want != got)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
                failures++;
            end
        endfunction

        function void check_pixel(input rgb15_px_t got);
            rgb15_px_t want;

            if (expected_pixels.size() == 0)
            begin
                $display("%0t: output transaction with none expected, actual %h",
                         $time, got);
                failures++;
                return;
            end
            want = expected_pixels.pop_front();
            compare_field("red_out", want.red, got.red);
            compare_field("green_out", want.green, got.green);
            compare_field("blue_out", want.blue, got.blue);
            compare_field("alpha_out", want.alpha, got.alpha);
            compare_field("frame_end", want.frame_end, got.frame_end);
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [CHAN_W-1:0]      red_in = '0;
    logic [CHAN_W-1:0]      green_in = '0;
    logic [CHAN_W-1:0]      blue_in = '0;
    logic [CHAN_W-1:0]      alpha_in = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [OUT_W-1:0]       red_out;
    logic [OUT_W-1:0]       green_out;
    logic [OUT_W-1:0]       blue_out;
    logic [CHAN_W-1:0]      alpha_out;
    logic                   frame_end;

    dither_scoreboard sb;
    int               pixels_sent = 0;
    int               idle_odds = 0;
    int               stall_odds = 0;
    int               stall_left = 0;
    bit               quiet = 1'b0;
    logic [CHAN_W-1:0] flat_base [NUM_CHAN];

    dither_rgb24_to_rgb15_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .alpha_in  (alpha_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out),
        .alpha_out (alpha_out),
        .frame_end (frame_end)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // Output side: ready drops in bursts of random length.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else if (!quiet && stall_odds != 0 && $urandom_range(1, stall_odds) == 1)
        begin
            out_ready <= 1'b0;
            stall_left = $urandom_range(0, 18);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_pixel('{red_out, green_out, blue_out, alpha_out, frame_end});
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_pixel(input logic [CHAN_W-1:0] r, g, b, a);
        @(negedge clk);
        in_valid <= 1'b1;
        red_in <= r;
        green_in <= g;
        blue_in <= b;
        alpha_in <= a;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_pixel(r, g, b, a);
        pixels_sent++;
    endtask

    task automatic idle_input(input int cycles);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (cycles - 1)
            @(negedge clk);
    endtask

    // Holds the input side off until every expected transaction has come out.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic [CHAN_W-1:0] pick_level(input texture_e texture,
                                                     input logic [CHAN_W-1:0] base);
        case (texture)
            TEXTURE_FLAT:    return base + CHAN_W'($urandom_range(0, 7));
            TEXTURE_EXTREME: return $urandom_range(0, 1) ? CHAN_W'($urandom_range(0, 7))
                                                         : CHAN_W'($urandom_range(248, 255));
            default:         return CHAN_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_textured(input texture_e texture);
        if (!quiet && idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
            idle_input($urandom_range(1, 19));
        else if (!quiet && $urandom_range(0, 199) == 0)
            drain();
        send_pixel(pick_level(texture, flat_base[0]), pick_level(texture, flat_base[1]),
                   pick_level(texture, flat_base[2]), CHAN_W'($urandom_range(0, 255)));
    endtask

    // A size change at a row boundary: a height of 1 to 8, or a width at most
    // the current one, so the next row reads only line entries the last row wrote.
    task automatic resize_mid_frame();
        drain();
        if ($urandom_range(0, 1))
            write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'($urandom_range(1, 8)));
        else
            write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'($urandom_range(1, sb.active_width())));
    endtask

    task automatic send_frame(input texture_e texture, input bit allow_resize);
        foreach (flat_base[i])
            flat_base[i] = CHAN_W'($urandom_range(0, 248));
        do
        begin
            send_textured(texture);
            if (allow_resize && !quiet && sb.at_row_start() && !sb.at_frame_start()
                && $urandom_range(0, 15) == 0)
                resize_mid_frame();
        end
        while (!sb.at_frame_start());
    endtask

    function automatic int pick_odds();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 3;
            2:       return 8;
            default: return 20;
        endcase
    endfunction

    initial
    begin
        logic [31:0] corner_px [12];
        logic [IMG_WIDTH_W-1:0] w;
        int random_start;

        sb = new();
        // Packed as {red, green, blue, alpha}; a 4x3 image of rounding corners.
        corner_px = '{32'h00000000, 32'hFFFFFFFF, 32'h04FCFB80, 32'h07038001,
                      32'hFF00FF55, 32'h00FF00AA, 32'hFFFFFF00, 32'h000000FF,
                      32'hFC04030F, 32'hFFFEFDF0, 32'h0102067F, 32'hF805FFC8};
        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_reg(REG_IMAGE_WIDTH, 13'd4);
        write_reg(REG_IMAGE_HEIGHT, 13'd3);
        foreach (corner_px[i])
            send_pixel(corner_px[i][31:24], corner_px[i][23:16],
                       corner_px[i][15:8], corner_px[i][7:0]);
        drain();

        // Single-pixel images: every transaction ends a frame.
        write_reg(REG_IMAGE_WIDTH, 13'd1);
        write_reg(REG_IMAGE_HEIGHT, 13'd1);
        send_pixel(8'hFF, 8'h00, 8'h04, 8'h00);
        send_pixel(8'h00, 8'hFF, 8'hFF, 8'hFF);
        drain();

        // Zero sizes count as one; bits above the width field are dropped.
        write_reg(REG_IMAGE_WIDTH, 13'h1800);
        write_reg(REG_IMAGE_HEIGHT, 13'd0);
        send_pixel(8'h05, 8'hFB, 8'h7C, 8'h33);
        send_pixel(8'hFC, 8'h03, 8'h84, 8'hCC);
        drain();

        write_reg(REG_SPARE_A, CFG_DATA_W'($urandom_range(0, 8191)));
        write_reg(REG_SPARE_B, 13'h1FFF);
        write_reg(REG_IMAGE_WIDTH, 13'd3);
        write_reg(REG_IMAGE_HEIGHT, 13'd2);
        send_frame(TEXTURE_NOISE, 1'b0);
        drain();

        // Widest row: the width saturates at the line store depth.
        idle_odds = 8;
        stall_odds = 8;
        write_reg(REG_IMAGE_WIDTH, 13'd2047);
        write_reg(REG_IMAGE_HEIGHT, 13'd1);
        send_frame(TEXTURE_NOISE, 1'b0);
        drain();

        random_start = pixels_sent;
        while (pixels_sent - random_start < RANDOM_PIXELS)
        begin
            drain();
            quiet = (pixels_sent - random_start >= CALM_PIXELS);
            idle_odds = pick_odds();
            stall_odds = pick_odds();
            case ($urandom_range(0, 19))
                0:       w = '0;
                1, 2, 3: w = IMG_WIDTH_W'($urandom_range(13, 48));
                default: w = IMG_WIDTH_W'($urandom_range(1, 12));
            endcase
            write_reg(REG_IMAGE_WIDTH, {2'($urandom_range(0, 3)), w});
            write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'($urandom_range(0, 7)));
            repeat ($urandom_range(1, 3))
                send_frame(texture_e'($urandom_range(0, 2)), 1'b1);
        end

        drain();
        repeat (10)
            @(posedge clk);
        if (sb.failures == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #(1_200_000 * 2 * HALF_PERIOD);
        $display("FAILURE");
        $finish;
    end

endmodule
